FILE: rtl/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer.
`default_nettype none
package wsd_pkg;

  // Opcodes that matter to the deframer
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // Configuration
  localparam int unsigned ADDR_W             = 3;
  localparam logic        REG_CHUNK_LIMIT    = 1'b0;
  localparam logic [15:0] CHUNK_LIMIT_RESET  = 16'd1024;

  // Classified item handed from the parser to the delivery stage
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/wsd_rx_if.sv
// Received byte channel: valid/ready with one byte of payload.
`default_nettype none
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/wsd_ev_if.sv
// Result channel: delivered payload bytes and the close event.
`default_nettype none
interface wsd_ev_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       chunk_end;
  logic       frame_end;

  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output chunk_end, output frame_end, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_opcode,
                  input chunk_end, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/wsd_front.sv
// Frame parser: walks the header, length and key, unmasks payload, classifies bytes.
`default_nettype none
module wsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  wsd_rx_if.sink               rx,
  input  wire wsd_pkg::q_stat_t q_stat,
  output logic                 push,
  output wsd_pkg::item_t       item
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR1   = 3'd0;
  localparam logic [2:0] PH_HDR2   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_MASK   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]  phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        mask_on, mask_on_next;
  logic [63:0] length_left, length_left_next;
  logic [3:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [2:0]  mask_bytes_left, mask_bytes_left_next;
  logic [1:0]  mask_phase, mask_phase_next;
  logic        closed, closed_next;

  logic        accept;
  logic        emit;
  item_t       item_c;
  logic [7:0]  b;
  logic [3:0]  lbl_dec;
  logic [2:0]  mbl_dec;
  logic [7:0]  key_byte;
  logic        last;
  logic        ld_fire, ld_mask, ld_len_zero;

  assign rx.ready = !q_stat.full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign push     = accept && emit;
  assign item     = item_c;

  // Pick the key byte by payload offset modulo four
  always_comb begin
    unique case (mask_phase)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign lbl_dec = (length_bytes_left != 4'd0) ? length_bytes_left - 4'd1 : 4'd0;
  assign mbl_dec = (mask_bytes_left != 3'd0) ? mask_bytes_left - 3'd1 : 3'd0;
  assign last    = (length_left == 64'd1);

  // Advance the parse state for the current byte
  always_comb begin
    phase_next             = phase;
    cur_opcode_next        = cur_opcode;
    mask_on_next           = mask_on;
    length_left_next       = length_left;
    length_bytes_left_next = length_bytes_left;
    mask_key_next          = mask_key;
    mask_bytes_left_next   = mask_bytes_left;
    mask_phase_next        = mask_phase;
    closed_next            = closed;
    emit                   = 1'b0;
    item_c                 = '0;
    ld_fire                = 1'b0;
    ld_mask                = 1'b0;
    ld_len_zero            = 1'b0;

    if (!closed) begin
      unique case (phase)
        PH_HDR2: begin
          mask_on_next     = b[7];
          length_left_next = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            length_bytes_left_next = 4'd2;
            phase_next             = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            length_bytes_left_next = 4'd8;
            phase_next             = PH_EXTLEN;
          end else begin
            length_left_next = {57'd0, b[6:0]};
            ld_fire          = 1'b1;
            ld_mask          = b[7];
            ld_len_zero      = (b[6:0] == 7'd0);
          end
        end
        PH_EXTLEN: begin
          length_left_next       = {length_left[55:0], b};
          length_bytes_left_next = lbl_dec;
          if (lbl_dec == 4'd0) begin
            ld_fire     = 1'b1;
            ld_mask     = mask_on;
            ld_len_zero = ({length_left[55:0], b} == 64'd0);
          end
        end
        PH_MASK: begin
          mask_key_next        = {mask_key[23:0], b};
          mask_bytes_left_next = mbl_dec;
          if (mbl_dec == 3'd0) begin
            ld_fire      = 1'b1;
            ld_mask      = 1'b0;
            ld_len_zero  = (length_left == 64'd0);
            mask_on_next = 1'b1;
          end
        end
        PH_DATA: begin
          mask_phase_next  = mask_phase + 2'd1;
          length_left_next = length_left - 64'd1;
          if (last) begin
            phase_next = PH_HDR1;
          end
          if (cur_opcode == OPC_TEXT || cur_opcode == OPC_BINARY) begin
            emit          = 1'b1;
            item_c.kind   = KIND_DATA;
            item_c.data   = mask_on ? (b ^ key_byte) : b;
            item_c.opcode = cur_opcode;
            item_c.last   = last;
          end else if (last && cur_opcode == OPC_CLOSE) begin
            emit          = 1'b1;
            item_c.kind   = KIND_CLOSE;
            item_c.opcode = OPC_CLOSE;
            item_c.last   = 1'b1;
            closed_next   = 1'b1;
          end
        end
        default: begin
          cur_opcode_next = b[3:0];
          phase_next      = PH_HDR2;
        end
      endcase

      // Header and length (or key) complete: enter key or payload, or return to the header for an empty frame
      if (ld_fire) begin
        if (ld_mask) begin
          mask_bytes_left_next = 3'd4;
          mask_key_next        = 32'd0;
          phase_next           = PH_MASK;
        end else begin
          mask_phase_next = 2'd0;
          if (ld_len_zero) begin
            phase_next = PH_HDR1;
            if (cur_opcode == OPC_CLOSE) begin
              emit          = 1'b1;
              item_c.kind   = KIND_CLOSE;
              item_c.opcode = OPC_CLOSE;
              item_c.last   = 1'b1;
              closed_next   = 1'b1;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
    end
  end

  // Hold state unless a byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR1;
      cur_opcode        <= 4'd0;
      mask_on           <= 1'b0;
      length_left       <= 64'd0;
      length_bytes_left <= 4'd0;
      mask_key          <= 32'd0;
      mask_bytes_left   <= 3'd0;
      mask_phase        <= 2'd0;
      closed            <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      cur_opcode        <= cur_opcode_next;
      mask_on           <= mask_on_next;
      length_left       <= length_left_next;
      length_bytes_left <= length_bytes_left_next;
      mask_key          <= mask_key_next;
      mask_bytes_left   <= mask_bytes_left_next;
      mask_phase        <= mask_phase_next;
      closed            <= closed_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wsd_queue.sv
// Two-entry queue between the parser and the delivery stage.
`default_nettype none
module wsd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wsd_pkg::item_t   push_item,
  input  wire logic             pop,
  output wsd_pkg::item_t        pop_item,
  output wsd_pkg::q_stat_t      q_stat
);
  import wsd_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_item     = slots[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wsd_back.sv
// Delivery stage: counts chunk bytes, marks chunk ends and drives the result register.
`default_nettype none
module wsd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [15:0]      chunk_limit,
  input  wire wsd_pkg::q_stat_t q_stat,
  input  wire wsd_pkg::item_t   q_item,
  output logic                  pop,
  wsd_ev_if.source              ev
);
  import wsd_pkg::*;

  logic [15:0] chunk_count;
  logic [15:0] cnt_inc;
  logic        cend;
  logic        out_valid;

  assign pop      = !q_stat.empty && (!out_valid || ev.ready);
  assign cnt_inc  = chunk_count + 16'd1;
  assign cend     = q_item.last || (cnt_inc >= chunk_limit);
  assign ev.valid = out_valid;

  // Load the result register when it frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      chunk_count <= 16'd0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (q_item.kind == KIND_DATA) begin
          chunk_count <= cend ? 16'd0 : cnt_inc;
        end
      end else if (ev.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev.kind         <= q_item.kind;
      ev.payload_byte <= q_item.data;
      ev.frame_opcode <= q_item.opcode;
      ev.frame_end    <= q_item.last;
      ev.chunk_end    <= (q_item.kind == KIND_CLOSE) ? 1'b1 : cend;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
// Top level of the websocket frame deframer.
// Usage:
//   rx  : one received byte per transaction (valid/ready, rx_byte).
//   ev  : one result per transaction: a payload byte of a text or binary
//         frame (kind 0) with chunk_end and frame_end marks, or the close
//         event (kind 1) once a close frame is complete.
//   APB : chunk_limit at byte address 0 (16 bits, reset 1024); write only
//         while no byte is in flight.
// Throughput is one byte per cycle while the queue has room. A byte is
// written to the queue at the edge it is taken, then moved into the result
// register once that register is free; its result is then held on ev until
// accepted. The parser keeps all per-byte state in registers; the 64-bit
// remaining-length decrement sets the path. After a close event all
// further bytes are accepted and dropped.
// Reset (rst, synchronous) returns to the first header byte, empties the
// two-entry queue and the result register, and restores chunk_limit.
// When ev stalls, the result register holds, the queue fills, and rx
// ready drops once both queue entries are taken.
`default_nettype none
module websocket_frame_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  wsd_rx_if.sink                           rx,
  wsd_ev_if.source                         ev,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import wsd_pkg::*;

  logic        q_push;
  logic        q_pop;
  item_t       push_item;
  item_t       pop_item;
  q_stat_t     q_stat;
  logic [15:0] chunk_limit;
  logic        reg_sel;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_CHUNK_LIMIT);
  assign prdata  = reg_sel ? {16'd0, chunk_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_limit <= CHUNK_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      chunk_limit <= pwdata[15:0];
    end
  end

  wsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_stat (q_stat),
    .push   (q_push),
    .item   (push_item)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  wsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .chunk_limit (chunk_limit),
    .q_stat      (q_stat),
    .q_item      (pop_item),
    .pop         (q_pop),
    .ev          (ev)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_close_marks: assert property (@(posedge clk) disable iff (rst)
    (ev.valid && ev.kind == KIND_CLOSE) |-> (ev.chunk_end && ev.frame_end))
    else $error("close event without end marks");

  a_frame_end_chunk: assert property (@(posedge clk) disable iff (rst)
    (ev.valid && ev.frame_end) |-> ev.chunk_end)
    else $error("frame end without chunk end");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Testbench for the websocket frame deframer: directed frames, random streams, closing frame.
`timescale 1ns / 100ps
module testbench;
  import wsd_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 1420;
  localparam int unsigned PHASE_COUNT    = 7;
  localparam logic [ADDR_W-1:0] CHUNK_LIMIT_ADDR = ADDR_W'(4 * REG_CHUNK_LIMIT);

  // Opcodes and header fields used only by the stimulus
  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;
  localparam logic [3:0] FLAGS_NONE = 4'h0;
  localparam logic [3:0] FIN_ONLY  = 4'h8;
  localparam logic [3:0] RSV_ONLY  = 4'h7;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       chunk_end;
    logic       frame_end;
  } event_t;

  typedef enum logic [2:0] {
    AT_HEADER1    = 3'd0,
    AT_HEADER2    = 3'd1,
    AT_EXT_LENGTH = 3'd2,
    AT_MASK_KEY   = 3'd3,
    AT_PAYLOAD    = 3'd4
  } parse_phase_e;

  typedef enum {FORM_COMPACT, FORM_EXT16, FORM_EXT64} len_form_e;

  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [15:0] value;
    logic        pinned;
    event_t      result;
  } script_row_t;

  localparam event_t NO_EVENT = '0;

  // Directed script: pinned rows carry the result typed in by hand
  localparam int SCRIPT_LEN = 29;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // zero limit behaves as one: every byte ends a chunk
    '{ROW_LIMIT, 16'd0, 1'b0, NO_EVENT},
    '{ROW_BYTE, {8'h00, FIN_ONLY, OPC_TEXT}, 1'b0, NO_EVENT},
    '{ROW_BYTE, {8'h00, 1'b0, 7'd3}, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b1, '{KIND_DATA, 8'h00, OPC_TEXT, 1'b1, 1'b0}},
    '{ROW_BYTE, 16'h00FF, 1'b1, '{KIND_DATA, 8'hFF, OPC_TEXT, 1'b1, 1'b0}},
    '{ROW_BYTE, 16'h0080, 1'b1, '{KIND_DATA, 8'h80, OPC_TEXT, 1'b1, 1'b1}},
    // masked binary frame with a 64-bit length and reserved bits set
    '{ROW_LIMIT, 16'd2, 1'b0, NO_EVENT},
    '{ROW_BYTE, {8'h00, RSV_ONLY, OPC_BINARY}, 1'b0, NO_EVENT},
    '{ROW_BYTE, {8'h00, 1'b1, LEN_EXT64}, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0003, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h00DE, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h00AD, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h00BE, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h00EF, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h00DE, 1'b1, '{KIND_DATA, 8'h00, OPC_BINARY, 1'b0, 1'b0}},
    '{ROW_BYTE, 16'h00AC, 1'b1, '{KIND_DATA, 8'h01, OPC_BINARY, 1'b1, 1'b0}},
    '{ROW_BYTE, 16'h0041, 1'b1, '{KIND_DATA, 8'hFF, OPC_BINARY, 1'b1, 1'b1}},
    // pong payload is dropped
    '{ROW_BYTE, {8'h00, FIN_ONLY, OPC_PONG}, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0001, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0055, 1'b0, NO_EVENT},
    // empty binary frame gives nothing
    '{ROW_BYTE, {8'h00, FLAGS_NONE, OPC_BINARY}, 1'b0, NO_EVENT},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_EVENT}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  wsd_rx_if rx_ch ();
  wsd_ev_if ev_ch ();

  websocket_frame_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .ev     (ev_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Deframer state mirrored by the predictor
  parse_phase_e rx_phase;
  logic [3:0]   opcode_q;
  logic         masked_q;
  logic [63:0]  bytes_to_go;
  logic [3:0]   len_bytes_to_go;
  logic [31:0]  mask_key_q;
  logic [2:0]   key_bytes_to_go;
  logic [1:0]   key_index;
  logic [15:0]  chunk_fill;
  logic         link_closed;
  logic [15:0]  chunk_limit_q;

  event_t       due_events [$];
  logic [7:0]   stream_bytes [$];
  bit           calm = 1'b0;
  int unsigned  ev_hold = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  frames_queued = 0;
  int           errors = 0;

  function automatic event_t close_event();
    link_closed = 1'b1;
    rx_phase = AT_HEADER1;
    return event_t'{KIND_CLOSE, 8'h00, OPC_CLOSE, 1'b1, 1'b1};
  endfunction

  // Header and length complete: collect the key or enter the payload
  function automatic bit finish_length(input bit key_ready, output event_t res);
    res = '0;
    if (masked_q && !key_ready) begin
      key_bytes_to_go = 3'd4;
      mask_key_q = '0;
      rx_phase = AT_MASK_KEY;
      return 1'b0;
    end
    key_index = '0;
    chunk_fill = '0;
    if (bytes_to_go == 64'd0) begin
      rx_phase = AT_HEADER1;
      if (opcode_q == OPC_CLOSE) begin
        res = close_event();
        return 1'b1;
      end
      return 1'b0;
    end
    rx_phase = AT_PAYLOAD;
    return 1'b0;
  endfunction

  // Advance the parser by one received byte; return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output event_t res);
    logic [7:0] plain;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       at_chunk_end;
    res = '0;
    if (link_closed) return 1'b0;
    case (rx_phase)
      AT_HEADER2: begin
        masked_q = b[7];
        bytes_to_go = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          len_bytes_to_go = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
          rx_phase = AT_EXT_LENGTH;
          return 1'b0;
        end
        bytes_to_go = 64'(b[6:0]);
        return finish_length(1'b0, res);
      end
      AT_EXT_LENGTH: begin
        bytes_to_go = {bytes_to_go[55:0], b};
        if (len_bytes_to_go != 0) len_bytes_to_go--;
        if (len_bytes_to_go == 0) return finish_length(1'b0, res);
        return 1'b0;
      end
      AT_MASK_KEY: begin
        mask_key_q = {mask_key_q[23:0], b};
        if (key_bytes_to_go != 0) key_bytes_to_go--;
        if (key_bytes_to_go == 0) return finish_length(1'b1, res);
        return 1'b0;
      end
      AT_PAYLOAD: begin
        // first key byte sits in the top bits
        key_byte = mask_key_q[8 * (3 - key_index) +: 8];
        plain = masked_q ? (b ^ key_byte) : b;
        key_index++;
        bytes_to_go--;
        last_byte = (bytes_to_go == 64'd0);
        if (last_byte) rx_phase = AT_HEADER1;
        if (opcode_q == OPC_TEXT || opcode_q == OPC_BINARY) begin
          chunk_fill++;
          at_chunk_end = last_byte || (chunk_fill >= chunk_limit_q);
          if (at_chunk_end) chunk_fill = '0;
          res = event_t'{KIND_DATA, plain, opcode_q, at_chunk_end, last_byte};
          return 1'b1;
        end
        if (last_byte && opcode_q == OPC_CLOSE) begin
          res = close_event();
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        opcode_q = b[3:0];
        rx_phase = AT_HEADER2;
        return 1'b0;
      end
    endcase
  endfunction

  // Mostly short pauses, a few long ones, none in calm stretches
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Append one frame to the outgoing byte stream
  task automatic queue_frame(input logic [3:0] opcode, input bit masked,
                             input int unsigned len, input len_form_e form);
    logic [63:0] len64;
    len64 = 64'(len);
    stream_bytes.push_back({4'($urandom), opcode});
    case (form)
      FORM_EXT16: begin
        stream_bytes.push_back({masked, LEN_EXT16});
        stream_bytes.push_back(len64[15:8]);
        stream_bytes.push_back(len64[7:0]);
      end
      FORM_EXT64: begin
        stream_bytes.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) stream_bytes.push_back(len64[8 * i +: 8]);
      end
      default: begin
        stream_bytes.push_back({masked, len64[6:0]});
      end
    endcase
    if (masked) repeat (4) stream_bytes.push_back(8'($urandom));
    repeat (len) stream_bytes.push_back(8'($urandom));
    frames_queued++;
  endtask

  // Hand one byte over and record what it should produce
  task automatic send_byte(input logic [7:0] b, input bit pinned, input event_t pinned_res);
    int unsigned gap;
    event_t      res;
    bit          produced;
    gap = pick_pause();
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    produced = deframe_byte(b, res);
    if (pinned) due_events.push_back(pinned_res);
    else if (produced) due_events.push_back(res);
    bytes_sent++;
  endtask

  // Drop valid, wait for every result, then let silent bytes finish
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CHUNK_LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_limit(input logic [15:0] want);
    logic [31:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback[15:0] !== want) begin
      $error("chunk_limit: expected %0h, got %0h", want, readback[15:0]);
      errors++;
    end
  endtask

  task automatic set_chunk_limit(input logic [15:0] limit);
    logic [31:0] unused_rdata;
    settle();
    apb_access(1'b1, {16'h0000, limit}, unused_rdata);
    chunk_limit_q = limit;
    @(posedge clk);
    read_limit(limit);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result receiver: random stalls on ready
  always @(posedge clk) begin
    if (ev_hold != 0) begin
      ev_ch.ready <= 1'b0;
      ev_hold--;
    end else begin
      ev_ch.ready <= 1'b1;
      ev_hold = pick_pause();
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    event_t want;
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: kind %0d, payload_byte %0h, frame_opcode %0h",
               ev_ch.kind, ev_ch.payload_byte, ev_ch.frame_opcode);
        errors++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", want.kind, ev_ch.kind);
        check_field("payload_byte", want.payload_byte, ev_ch.payload_byte);
        check_field("frame_opcode", want.frame_opcode, ev_ch.frame_opcode);
        check_field("chunk_end", want.chunk_end, ev_ch.chunk_end);
        check_field("frame_end", want.frame_end, ev_ch.frame_end);
        results_seen++;
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0]  limits [PHASE_COUNT];
    int unsigned  r;
    int unsigned  phase_end;
    int unsigned  frame_len;
    logic [3:0]   frame_op;
    len_form_e    frame_form;

    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    rx_phase        = AT_HEADER1;
    opcode_q        = '0;
    masked_q        = 1'b0;
    bytes_to_go     = '0;
    len_bytes_to_go = '0;
    mask_key_q      = '0;
    key_bytes_to_go = '0;
    key_index       = '0;
    chunk_fill      = '0;
    link_closed     = 1'b0;
    chunk_limit_q   = CHUNK_LIMIT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    read_limit(CHUNK_LIMIT_RESET);

    // Walk the directed script
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].op == ROW_LIMIT) set_chunk_limit(SCRIPT[i].value);
      else send_byte(SCRIPT[i].value[7:0], SCRIPT[i].pinned, SCRIPT[i].result);
    end

    // Random frames; the limit changes between phases, often mid-frame
    limits = '{16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(3, 9)),
               16'($urandom_range(10, 64)), 16'($urandom_range(1, 65535)), 16'd5};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_chunk_limit(limits[p]);
      calm = (p == 3);
      phase_end = bytes_sent + RANDOM_BYTES / PHASE_COUNT;
      while (bytes_sent < phase_end) begin
        if (stream_bytes.size() == 0) begin
          r = $urandom_range(0, 9);
          if (r < 3) frame_op = OPC_TEXT;
          else if (r < 6) frame_op = OPC_BINARY;
          else if (r == 6) frame_op = OPC_CONT;
          else if (r == 7) frame_op = OPC_PING;
          else if (r == 8) frame_op = OPC_PONG;
          else begin
            // reserved opcodes 3..7 and 11..15
            r = $urandom_range(3, 12);
            frame_op = 4'((r < 8) ? r : r + 3);
          end
          r = $urandom_range(0, 19);
          if (r == 0) frame_len = 0;
          else if (r < 13) frame_len = $urandom_range(1, 12);
          else if (r < 18) frame_len = $urandom_range(13, 125);
          else if (r == 18) frame_len = $urandom_range(126, 320);
          else frame_len = $urandom_range(0, 40);
          r = $urandom_range(0, 9);
          if (frame_len > 125 || r == 0) frame_form = FORM_EXT16;
          else if (r == 1) frame_form = FORM_EXT64;
          else frame_form = FORM_COMPACT;
          queue_frame(frame_op, 1'($urandom), frame_len, frame_form);
        end
        send_byte(stream_bytes.pop_front(), 1'b0, NO_EVENT);
      end
    end
    calm = 1'b0;

    // Finish the open frame, close the connection, then feed bytes to be ignored
    r = $urandom_range(0, 3);
    case (r)
      0:       queue_frame(OPC_CLOSE, 1'b0, 0, FORM_COMPACT);
      1:       queue_frame(OPC_CLOSE, 1'b0, 0, FORM_EXT16);
      2:       queue_frame(OPC_CLOSE, 1'b1, 0, FORM_COMPACT);
      default: queue_frame(OPC_CLOSE, 1'b1, $urandom_range(1, 6), FORM_COMPACT);
    endcase
    repeat (12) stream_bytes.push_back(8'($urandom));
    stream_bytes.push_back({FIN_ONLY, OPC_CLOSE});
    stream_bytes.push_back(8'h00);
    repeat (12) stream_bytes.push_back(8'($urandom));
    while (stream_bytes.size() != 0) send_byte(stream_bytes.pop_front(), 1'b0, NO_EVENT);

    settle();
    $display("Sent %0d bytes (%0d generated frames plus a directed script), checked %0d results.",
             bytes_sent, frames_queued, results_seen);
    $display("Chunk limits 0, 1, 2, 65535 and random values used; run ended after a close frame.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
